// File: hdl/sdgs_pkg.sv
// sdgs_pkg: shared types and constants for the stick to d-pad gesture shift
// holds register indexes, reset values, modifier source codes and d-pad codes
// no dependencies
`default_nettype none

package sdgs_pkg;

   // configuration port widths
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   // register indexes on the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MODIFIER_SOURCE = 3'd0,
      REG_HEAD_MIN_HEIGHT = 3'd1,
      REG_HEAD_RADIUS     = 3'd2,
      REG_DWELL_MS        = 3'd3,
      REG_STICK_DEADZONE  = 3'd4
   } reg_index_type;

   // where the modifier comes from
   typedef enum logic [1:0] {
      MOD_OFF       = 2'd0,
      MOD_THUMBREST = 2'd1,
      MOD_HEAD      = 2'd2,
      MOD_EITHER    = 2'd3
   } mod_source_type;

   // d-pad button codes
   localparam logic [3:0] DPAD_NONE  = 4'h0;
   localparam logic [3:0] DPAD_UP    = 4'h1;
   localparam logic [3:0] DPAD_DOWN  = 4'h2;
   localparam logic [3:0] DPAD_LEFT  = 4'h4;
   localparam logic [3:0] DPAD_RIGHT = 4'h8;

   // controller flag bit positions
   localparam int unsigned FLAG_THUMB_L  = 0;
   localparam int unsigned FLAG_THUMB_R  = 1;
   localparam int unsigned FLAG_TRACKED  = 2;
   localparam int unsigned FLAG_HEAD_OK  = 3;
   localparam int unsigned FLAG_PRIMARY  = 4;

   // register reset values and write limits
   localparam logic signed [15:0] HEIGHT_RESET   = -16'sd614;
   localparam logic [13:0]        RADIUS_RESET   = 14'd1843;
   localparam logic [13:0]        RADIUS_MIN     = 14'd205;
   localparam logic [15:0]        DWELL_RESET    = 16'd0;
   localparam logic [13:0]        DEADZONE_RESET = 14'd9830;
   localparam logic [13:0]        DEADZONE_MIN   = 14'd820;
   localparam logic [27:0]        RADIUS_SQ_RESET = 28'd3396649;

endpackage

`default_nettype wire

// File: hdl/stick_to_dpad_gesture_shift.sv
// stick_to_dpad_gesture_shift: top level of the gesture shift block
// two register stages: input word, result word
// depends on sdgs_pkg
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/ready    | flags, hand and head xyz, stick xy, now_ms
//   rsp_    | out       | rsp_valid/ready    | engaged, dpad_buttons, view, two pulses
//   csr_    | in        | csr_valid/ready    | csr_index, csr_data
//
// one word is taken every cycle unless the result stalls; each word goes through the input
// register, then the result register, to rsp_; the two 16x16 squarers sit between them
// both stages move together: a stalled result holds the whole pipe and drops req_ready
// synchronous reset clears the valid bits, the modifier history and the configuration registers
// csr writes are taken in any cycle outside reset and land at once
`default_nettype none

module stick_to_dpad_gesture_shift (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // input words
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [4:0]                         req_controller_flags,
   input  wire logic signed [15:0]                 req_hand_x,
   input  wire logic signed [15:0]                 req_hand_y,
   input  wire logic signed [15:0]                 req_hand_z,
   input  wire logic signed [15:0]                 req_head_x,
   input  wire logic signed [15:0]                 req_head_y,
   input  wire logic signed [15:0]                 req_head_z,
   input  wire logic signed [15:0]                 req_stick_x,
   input  wire logic signed [15:0]                 req_stick_y,
   input  wire logic [31:0]                        req_now_ms,
   // result words
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_engaged,
   output logic [3:0]                              rsp_dpad_buttons,
   output logic                                    rsp_view_button,
   output logic                                    rsp_engage_pulse,
   output logic                                    rsp_view_pulse,
   // register writes
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [sdgs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [sdgs_pkg::CSR_DATA_W-1:0]    csr_data
);
   import sdgs_pkg::*;

   // configuration registers
   mod_source_type     source_ff;
   logic signed [15:0] min_height_ff;
   logic [27:0]        radius_sq_ff;
   logic [15:0]        dwell_ff;
   logic [13:0]        deadzone_ff;

   // pipe control
   logic advance;
   logic p1_valid_ff, rsp_valid_ff;

   // input register
   logic [4:0]         p1_flags_ff;
   logic signed [15:0] p1_hand_x_ff, p1_hand_y_ff, p1_hand_z_ff;
   logic signed [15:0] p1_head_x_ff, p1_head_y_ff, p1_head_z_ff;
   logic signed [15:0] p1_stick_x_ff, p1_stick_y_ff;
   logic [31:0]        p1_now_ff;

   // offsets, squares and stick direction
   logic signed [16:0] dx, dy, dz, lx, ly, ax, ay, dz_pos, dz_neg, height_ext;
   logic [15:0]        adx, adz;
   logic [31:0]        sq_x, sq_z;
   logic [3:0]         dir_in;
   logic               height_ok;

   // modifier decision and history
   logic [32:0] dist_sq;
   logic        thumb, head_ok, held, rise, dwell_done, engaged_in, view_in;
   logic [31:0] elapsed;
   logic        was_held_ff, engaged_last_ff, view_last_ff;
   logic [31:0] since_ff;
   logic        rsp_engaged_ff, rsp_view_ff, rsp_engage_pulse_ff, rsp_view_pulse_ff;
   logic [3:0]  rsp_dpad_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance && !reset;
   assign csr_ready = !reset;

   // register writes; small radius and deadzone values are dropped
   // the radius is kept only as its square
   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff     <= MOD_EITHER;
         min_height_ff <= HEIGHT_RESET;
         radius_sq_ff  <= RADIUS_SQ_RESET;
         dwell_ff      <= DWELL_RESET;
         deadzone_ff   <= DEADZONE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MODIFIER_SOURCE: source_ff <= mod_source_type'(csr_data[1:0]);
            REG_HEAD_MIN_HEIGHT: min_height_ff <= signed'(csr_data);
            REG_HEAD_RADIUS: begin
               if (csr_data[13:0] >= RADIUS_MIN)
                  radius_sq_ff <= csr_data[13:0] * csr_data[13:0];
            end
            REG_DWELL_MS: dwell_ff <= csr_data;
            REG_STICK_DEADZONE: begin
               if (csr_data[13:0] >= DEADZONE_MIN) deadzone_ff <= csr_data[13:0];
            end
            default: ;
         endcase
      end
   end

   // valid bits move with the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff  <= req_valid;
         rsp_valid_ff <= p1_valid_ff;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (advance) begin
         p1_flags_ff   <= req_controller_flags;
         p1_hand_x_ff  <= req_hand_x;
         p1_hand_y_ff  <= req_hand_y;
         p1_hand_z_ff  <= req_hand_z;
         p1_head_x_ff  <= req_head_x;
         p1_head_y_ff  <= req_head_y;
         p1_head_z_ff  <= req_head_z;
         p1_stick_x_ff <= req_stick_x;
         p1_stick_y_ff <= req_stick_y;
         p1_now_ff     <= req_now_ms;
      end
   end

   // hand to head offsets, squares, height test
   always_comb begin
      dx = 17'(p1_hand_x_ff) - 17'(p1_head_x_ff);
      dy = 17'(p1_hand_y_ff) - 17'(p1_head_y_ff);
      dz = 17'(p1_hand_z_ff) - 17'(p1_head_z_ff);
      adx = dx[16] ? 16'(-dx) : dx[15:0];
      adz = dz[16] ? 16'(-dz) : dz[15:0];
      sq_x = adx * adx;
      sq_z = adz * adz;
      height_ext = 17'(min_height_ff);
      height_ok  = dy >= height_ext;
   end

   // dominant stick axis against the deadzone
   always_comb begin
      lx = 17'(p1_stick_x_ff);
      ly = 17'(p1_stick_y_ff);
      ax = lx[16] ? -lx : lx;
      ay = ly[16] ? -ly : ly;
      dz_pos = signed'({3'b000, deadzone_ff});
      dz_neg = -dz_pos;
      dir_in = DPAD_NONE;
      if (ay >= ax) begin
         if (ly >= dz_pos)      dir_in = DPAD_UP;
         else if (ly <= dz_neg) dir_in = DPAD_DOWN;
      end else begin
         if (lx >= dz_pos)      dir_in = DPAD_RIGHT;
         else if (lx <= dz_neg) dir_in = DPAD_LEFT;
      end
   end

   // modifier decision and dwell timing
   always_comb begin
      dist_sq = {1'b0, sq_x} + {1'b0, sq_z};
      thumb   = p1_flags_ff[FLAG_THUMB_L] || p1_flags_ff[FLAG_THUMB_R];
      head_ok = p1_flags_ff[FLAG_TRACKED] && p1_flags_ff[FLAG_HEAD_OK]
                && height_ok && (dist_sq <= {5'b0, radius_sq_ff});
      unique case (source_ff)
         MOD_OFF:       held = 1'b0;
         MOD_THUMBREST: held = thumb;
         MOD_HEAD:      held = head_ok;
         MOD_EITHER:    held = thumb || head_ok;
         default:       held = 1'b0;
      endcase
      rise       = held && !was_held_ff;
      elapsed    = p1_now_ff - since_ff;
      dwell_done = rise ? (dwell_ff == 16'd0) : (elapsed >= {16'b0, dwell_ff});
      engaged_in = held && dwell_done;
      view_in    = engaged_in && p1_flags_ff[FLAG_PRIMARY];
   end

   // history, updated once per word as it enters the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         was_held_ff     <= 1'b0;
         since_ff        <= '0;
         engaged_last_ff <= 1'b0;
         view_last_ff    <= 1'b0;
      end else if (advance && p1_valid_ff) begin
         was_held_ff     <= held;
         if (rise) since_ff <= p1_now_ff;
         engaged_last_ff <= engaged_in;
         view_last_ff    <= view_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_engaged_ff      <= engaged_in;
         rsp_dpad_ff         <= engaged_in ? dir_in : DPAD_NONE;
         rsp_view_ff         <= view_in;
         rsp_engage_pulse_ff <= engaged_in && !engaged_last_ff;
         rsp_view_pulse_ff   <= view_in && !view_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_engaged      = rsp_engaged_ff;
   assign rsp_dpad_buttons = rsp_dpad_ff;
   assign rsp_view_button  = rsp_view_ff;
   assign rsp_engage_pulse = rsp_engage_pulse_ff;
   assign rsp_view_pulse   = rsp_view_pulse_ff;

endmodule

`default_nettype wire

// File: hdl/sdgs_checker.sv
// sdgs_checker: port level checks on the gesture shift result channel
// bound to stick_to_dpad_gesture_shift; depends on sdgs_pkg
`default_nettype none

module sdgs_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_engaged,
   input wire logic [3:0] rsp_dpad_buttons,
   input wire logic       rsp_view_button,
   input wire logic       rsp_engage_pulse,
   input wire logic       rsp_view_pulse
);
   import sdgs_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_engaged)
         && $stable(rsp_dpad_buttons) && $stable(rsp_view_button))
      else $error("result word changed while stalled");

   // d-pad and view only while engaged
   a_dpad_engaged: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_dpad_buttons != DPAD_NONE || rsp_view_button) |-> rsp_engaged)
      else $error("d-pad or view without engaged");

   // at most one d-pad direction
   a_dpad_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_dpad_buttons))
      else $error("more than one d-pad direction");

   // pulses only with their level
   a_pulse_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_engage_pulse || rsp_view_pulse)
         |-> (!rsp_engage_pulse || rsp_engaged) && (!rsp_view_pulse || rsp_view_button))
      else $error("pulse without its level");

   // two accepted engaged words in a row cannot both carry the engage pulse
   a_no_double_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_engaged ##1 rsp_valid && rsp_ready
         |-> !rsp_engage_pulse)
      else $error("engage pulse while already engaged");

endmodule

bind stick_to_dpad_gesture_shift sdgs_checker u_sdgs_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_engaged      (rsp_engaged),
   .rsp_dpad_buttons (rsp_dpad_buttons),
   .rsp_view_button  (rsp_view_button),
   .rsp_engage_pulse (rsp_engage_pulse),
   .rsp_view_pulse   (rsp_view_pulse)
);

`default_nettype wire

// File: test/stick_to_dpad_gesture_shift_test.sv
// stick_to_dpad_gesture_shift_test: self-checking bench for the gesture shift block
// streams controller frames through u_top and checks every result word against a local model
// depends on sdgs_pkg and stick_to_dpad_gesture_shift
module stick_to_dpad_gesture_shift_test;
   import sdgs_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam logic [4:0] THUMB_L_BIT = 5'(1 << FLAG_THUMB_L);
   localparam logic [4:0] THUMB_R_BIT = 5'(1 << FLAG_THUMB_R);
   localparam logic [4:0] TRACKED_BIT = 5'(1 << FLAG_TRACKED);
   localparam logic [4:0] HEAD_OK_BIT = 5'(1 << FLAG_HEAD_OK);
   localparam logic [4:0] PRIMARY_BIT = 5'(1 << FLAG_PRIMARY);
   localparam logic [4:0] HEAD_PAIR   = TRACKED_BIT | HEAD_OK_BIT;

   typedef struct {
      logic [4:0]         flags;
      logic signed [15:0] hand_x, hand_y, hand_z;
      logic signed [15:0] head_x, head_y, head_z;
      logic signed [15:0] stick_x, stick_y;
      logic [31:0]        now_ms;
   } shift_frame_type;

   typedef struct {
      logic       engaged;
      logic [3:0] dpad;
      logic       view;
      logic       engage_pulse;
      logic       view_pulse;
   } shift_result_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   // block ports
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [4:0]           req_controller_flags = '0;
   logic signed [15:0]   req_hand_x = '0, req_hand_y = '0, req_hand_z = '0;
   logic signed [15:0]   req_head_x = '0, req_head_y = '0, req_head_z = '0;
   logic signed [15:0]   req_stick_x = '0, req_stick_y = '0;
   logic [31:0]          req_now_ms = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_engaged;
   logic [3:0]           rsp_dpad_buttons;
   logic                 rsp_view_button;
   logic                 rsp_engage_pulse;
   logic                 rsp_view_pulse;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   stick_to_dpad_gesture_shift u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_controller_flags (req_controller_flags),
      .req_hand_x           (req_hand_x),
      .req_hand_y           (req_hand_y),
      .req_hand_z           (req_hand_z),
      .req_head_x           (req_head_x),
      .req_head_y           (req_head_y),
      .req_head_z           (req_head_z),
      .req_stick_x          (req_stick_x),
      .req_stick_y          (req_stick_y),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_engaged          (rsp_engaged),
      .rsp_dpad_buttons     (rsp_dpad_buttons),
      .rsp_view_button      (rsp_view_button),
      .rsp_engage_pulse     (rsp_engage_pulse),
      .rsp_view_pulse       (rsp_view_pulse),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   // register mirror
   mod_source_type     cfg_source   = MOD_EITHER;
   logic signed [15:0] cfg_min_height = HEIGHT_RESET;
   logic [13:0]        cfg_radius   = RADIUS_RESET;
   logic [15:0]        cfg_dwell    = DWELL_RESET;
   logic [13:0]        cfg_deadzone = DEADZONE_RESET;

   // modifier and edge history
   bit          mod_held_prev = 1'b0;
   logic [31:0] mod_start     = '0;
   bit          engaged_prev  = 1'b0;
   bit          view_prev     = 1'b0;

   // frames waiting to go out, and result words still owed by the block
   shift_frame_type  frames_to_send[$];
   shift_result_type shift_expected[$];
   int            frames_in_flight = 0;
   int            mismatches = 0;
   int            quiet_cycles = 0;
   logic [31:0]   clock_ms = '0;

   function automatic int pick(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // works out the result word for one frame and advances the history
   function automatic shift_result_type predict_shift(input shift_frame_type f);
      shift_result_type r;
      bit          thumb, near_head, held;
      int          dx, dy, dz, sx, sy, ax, ay, dead;
      longint      span2, rad2;
      logic [31:0] elapsed;
      thumb = f.flags[FLAG_THUMB_L] || f.flags[FLAG_THUMB_R];
      near_head = 1'b0;
      if (f.flags[FLAG_TRACKED] && f.flags[FLAG_HEAD_OK]) begin
         dx = int'(f.hand_x) - int'(f.head_x);
         dy = int'(f.hand_y) - int'(f.head_y);
         dz = int'(f.hand_z) - int'(f.head_z);
         span2 = longint'(dx) * dx + longint'(dz) * dz;
         rad2 = longint'(cfg_radius) * longint'(cfg_radius);
         near_head = (dy >= int'(cfg_min_height)) && (span2 <= rad2);
      end
      case (cfg_source)
         MOD_OFF:       held = 1'b0;
         MOD_THUMBREST: held = thumb;
         MOD_HEAD:      held = near_head;
         default:       held = thumb || near_head;
      endcase
      // start time latched on the rising edge of the modifier
      if (held && !mod_held_prev) mod_start = f.now_ms;
      mod_held_prev = held;
      elapsed = f.now_ms - mod_start;
      r.engaged = held && (elapsed >= 32'(cfg_dwell));
      r.engage_pulse = r.engaged && !engaged_prev;
      engaged_prev = r.engaged;
      // dominant axis, vertical wins a tie
      r.dpad = DPAD_NONE;
      if (r.engaged) begin
         sx = int'(f.stick_x);
         sy = int'(f.stick_y);
         ax = (sx < 0) ? -sx : sx;
         ay = (sy < 0) ? -sy : sy;
         dead = int'(cfg_deadzone);
         if (ay >= ax) begin
            if (sy >= dead) r.dpad = DPAD_UP;
            else if (sy <= -dead) r.dpad = DPAD_DOWN;
         end else begin
            if (sx >= dead) r.dpad = DPAD_RIGHT;
            else if (sx <= -dead) r.dpad = DPAD_LEFT;
         end
      end
      r.view = r.engaged && f.flags[FLAG_PRIMARY];
      r.view_pulse = r.view && !view_prev;
      view_prev = r.view;
      return r;
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (reg_index_type'(idx))
         REG_MODIFIER_SOURCE: cfg_source = mod_source_type'(data[1:0]);
         REG_HEAD_MIN_HEIGHT: cfg_min_height = data;
         REG_HEAD_RADIUS:     if (data[13:0] >= RADIUS_MIN) cfg_radius = data[13:0];
         REG_DWELL_MS:        cfg_dwell = data;
         REG_STICK_DEADZONE:  if (data[13:0] >= DEADZONE_MIN) cfg_deadzone = data[13:0];
         default: ;
      endcase
   endfunction

   function automatic shift_frame_type make_frame(input logic [4:0] flags,
                                               input int hx, input int hy, input int hz,
                                               input int ex, input int ey, input int ez,
                                               input int sx, input int sy,
                                               input logic [31:0] ms);
      shift_frame_type f;
      f.flags = flags;
      f.hand_x = 16'(hx);
      f.hand_y = 16'(hy);
      f.hand_z = 16'(hz);
      f.head_x = 16'(ex);
      f.head_y = 16'(ey);
      f.head_z = 16'(ez);
      f.stick_x = 16'(sx);
      f.stick_y = 16'(sy);
      f.now_ms = ms;
      return f;
   endfunction

   task automatic queue_frame(input shift_frame_type f);
      frames_in_flight++;
      frames_to_send.push_back(f);
   endtask

   // called just after a rising edge; returns just after one
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      while (frames_in_flight != 0 || shift_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register settings for each random phase, extremes included
   task automatic configure(input int phase);
      logic [1:0]  src;
      logic [15:0] height, dwell;
      logic [13:0] rad, dead;
      case (phase)
         0: begin
            src = MOD_EITHER; height = 16'(pick(-2000, 500)); rad = 14'(pick(205, 4000));
            dwell = 16'(pick(0, 200)); dead = 14'(pick(820, 16383));
         end
         1: begin
            src = MOD_THUMBREST; height = 16'h8000; rad = 14'd16383;
            dwell = 16'd0; dead = DEADZONE_MIN;
         end
         2: begin
            src = MOD_HEAD; height = 16'h8000; rad = RADIUS_MIN;
            dwell = 16'hffff; dead = 14'd16383;
         end
         3: begin
            src = MOD_EITHER; height = 16'h7fff; rad = 14'd16383;
            dwell = 16'd1; dead = DEADZONE_MIN;
         end
         4: begin
            src = MOD_OFF; height = 16'(pick(-1000, 0)); rad = 14'd2000;
            dwell = 16'd50; dead = 14'd8000;
         end
         default: begin
            src = 2'($urandom_range(0, 3)); height = 16'(pick(-3000, 1000));
            rad = 14'($urandom_range(0, 8000));
            dwell = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
            dead = 14'($urandom_range(500, 16383));
         end
      endcase
      write_reg(REG_MODIFIER_SOURCE, {14'($urandom), src});
      write_reg(REG_HEAD_MIN_HEIGHT, height);
      write_reg(REG_HEAD_RADIUS, {2'($urandom), rad});
      write_reg(REG_DWELL_MS, dwell);
      write_reg(REG_STICK_DEADZONE, {2'($urandom), dead});
      // writes that must leave the registers alone
      if (phase == 4) begin
         write_reg(REG_HEAD_RADIUS, {2'b11, RADIUS_MIN - 14'd1});
         write_reg(REG_STICK_DEADZONE, {2'b11, DEADZONE_MIN - 14'd1});
         write_reg(REG_HEAD_RADIUS, 16'd0);
         for (int i = int'(REG_STICK_DEADZONE) + 1; i < 2 ** CSR_INDEX_W; i++)
            write_reg(CSR_INDEX_W'(i), 16'($urandom));
      end
   endtask

   // random sessions: runs of frames holding one gesture, with time moving forward
   task automatic queue_sessions(input int count);
      shift_frame_type f;
      int style, len, step_max, made, r, dead, mode, sx, sy, near, other;
      made = 0;
      while (made < count) begin
         style = $urandom_range(0, 9);
         len = $urandom_range(1, 14);
         case ($urandom_range(0, 2))
            0:       step_max = 40;
            1:       step_max = 400;
            default: step_max = 6000;
         endcase
         repeat (len) begin
            r = int'(cfg_radius);
            dead = int'(cfg_deadzone);
            f.flags = 5'($urandom);
            f.head_x = 16'(pick(-4000, 4000));
            f.head_y = 16'(pick(-4000, 4000));
            f.head_z = 16'(pick(-4000, 4000));
            if (style == 9) begin
               // plain noise over every field
               f.hand_x = 16'($urandom);
               f.hand_y = 16'($urandom);
               f.hand_z = 16'($urandom);
               f.head_x = 16'($urandom);
               f.head_y = 16'($urandom);
               f.head_z = 16'($urandom);
               f.stick_x = 16'($urandom);
               f.stick_y = 16'($urandom);
               f.now_ms = $urandom;
            end else begin
               if (style <= 2 || style == 6) f.flags[1:0] = 2'($urandom_range(1, 3));
               else f.flags[1:0] = 2'b00;
               if (style >= 3 && style <= 6) begin
                  f.flags[FLAG_TRACKED] = 1'b1;
                  f.flags[FLAG_HEAD_OK] = 1'b1;
                  f.hand_x = 16'(int'(f.head_x) + pick(-r, r));
                  f.hand_z = 16'(int'(f.head_z) + pick(-r, r));
                  f.hand_y = 16'(int'(f.head_y) + int'(cfg_min_height) + pick(-40, 400));
               end else begin
                  f.hand_x = 16'(int'(f.head_x) + pick(-20000, 20000));
                  f.hand_y = 16'(int'(f.head_y) + pick(-20000, 20000));
                  f.hand_z = 16'(int'(f.head_z) + pick(-20000, 20000));
               end
               // occasional dropout of thumbs or tracking mid-session
               if ($urandom_range(0, 7) == 0) f.flags[3:0] = 4'($urandom);
               mode = $urandom_range(0, 3);
               case (mode)
                  0: begin
                     sx = pick(-16384, 16384);
                     sy = pick(-16384, 16384);
                  end
                  1: begin
                     near = (($urandom_range(0, 1) != 0) ? dead : -dead) + pick(-2, 2);
                     other = pick(-dead / 2, dead / 2);
                     if ($urandom_range(0, 1) != 0) begin
                        sx = near;
                        sy = other;
                     end else begin
                        sx = other;
                        sy = near;
                     end
                  end
                  2: begin
                     sx = int'($urandom_range(0, 65535));
                     sy = int'($urandom_range(0, 65535));
                  end
                  default: begin
                     sx = pick(0, 16384);
                     sy = ($urandom_range(0, 1) != 0) ? sx : -sx;
                     if ($urandom_range(0, 1) != 0) sx = -sx;
                  end
               endcase
               f.stick_x = 16'(sx);
               f.stick_y = 16'(sy);
               clock_ms = clock_ms + 32'($urandom_range(0, step_max));
               f.now_ms = clock_ms;
            end
            queue_frame(f);
            made++;
         end
      end
   endtask

   // sender: bursts of words with random gaps between them
   shift_frame_type frame_on_wire;
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin : sender
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            shift_expected.push_back(predict_shift(frame_on_wire));
            frames_in_flight--;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0 || frames_to_send.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               frame_on_wire = frames_to_send.pop_front();
               req_controller_flags <= frame_on_wire.flags;
               req_hand_x <= frame_on_wire.hand_x;
               req_hand_y <= frame_on_wire.hand_y;
               req_hand_z <= frame_on_wire.hand_z;
               req_head_x <= frame_on_wire.head_x;
               req_head_y <= frame_on_wire.head_y;
               req_head_z <= frame_on_wire.head_z;
               req_stick_x <= frame_on_wire.stick_x;
               req_stick_y <= frame_on_wire.stick_y;
               req_now_ms <= frame_on_wire.now_ms;
               req_valid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 48);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   task automatic report_field(input string name, input logic [3:0] want,
                               input logic [3:0] got);
      $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
      mismatches++;
   endtask

   // receiver: checks each result word, stalls on its own pattern, one long hold-off
   int  results_seen = 0;
   int  stall_count = 0;
   int  stall_mode = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   always @(posedge clock) begin : result_check
      shift_result_type want;
      logic          ready_next;
      if (!reset && rsp_valid && rsp_ready) begin
         if (shift_expected.size() == 0) begin
            $display("%0t: result word with nothing expected", $time);
            mismatches++;
         end else begin
            want = shift_expected.pop_front();
            if (rsp_engaged !== want.engaged)
               report_field("engaged", 4'(want.engaged), 4'(rsp_engaged));
            if (rsp_dpad_buttons !== want.dpad)
               report_field("dpad_buttons", want.dpad, rsp_dpad_buttons);
            if (rsp_view_button !== want.view)
               report_field("view_button", 4'(want.view), 4'(rsp_view_button));
            if (rsp_engage_pulse !== want.engage_pulse)
               report_field("engage_pulse", 4'(want.engage_pulse), 4'(rsp_engage_pulse));
            if (rsp_view_pulse !== want.view_pulse)
               report_field("view_pulse", 4'(want.view_pulse), 4'(rsp_view_pulse));
         end
         results_seen++;
      end
      stall_count++;
      if (stall_count % 97 == 0) stall_mode = $urandom_range(0, 3);
      if (!hold_done && results_seen >= 120) begin
         hold_left = 80;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         ready_next = 1'b0;
      end else begin
         case (stall_mode)
            0:       ready_next = 1'b1;
            1:       ready_next = 1'($urandom_range(0, 1));
            2:       ready_next = (stall_count % 8) >= 3;
            default: ready_next = ($urandom_range(0, 7) != 0);
         endcase
      end
      rsp_ready <= reset ? 1'b0 : ready_next;
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // stimulus sequence
   initial begin : stimulus
      logic [31:0] t;
      clock_ms = $urandom;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed frames at reset settings
      t = 32'd1000;
      queue_frame(make_frame(5'd0, 0, 0, 0, 0, 0, 0, 0, 0, t));
      queue_frame(make_frame(THUMB_L_BIT, 0, 0, 0, 0, 0, 0, 0, 16384, t + 1));
      queue_frame(make_frame(THUMB_L_BIT, 0, 0, 0, 0, 0, 0, 0, -16384, t + 2));
      queue_frame(make_frame(THUMB_R_BIT, 0, 0, 0, 0, 0, 0, -16384, 0, t + 3));
      queue_frame(make_frame(THUMB_L_BIT | THUMB_R_BIT, 0, 0, 0, 0, 0, 0, 16384, 0, t + 4));
      // deadzone edge, exactly on and one below
      queue_frame(make_frame(THUMB_L_BIT, 0, 0, 0, 0, 0, 0, 9830, 0, t + 5));
      queue_frame(make_frame(THUMB_L_BIT, 0, 0, 0, 0, 0, 0, 9829, 0, t + 6));
      queue_frame(make_frame(THUMB_L_BIT, 0, 0, 0, 0, 0, 0, 0, -9830, t + 7));
      // equal magnitudes go vertical; out-of-range axis patterns
      queue_frame(make_frame(THUMB_L_BIT, 0, 0, 0, 0, 0, 0, 12000, -12000, t + 8));
      queue_frame(make_frame(THUMB_L_BIT, 0, 0, 0, 0, 0, 0, -32768, 32767, t + 9));
      // view button and its edge
      queue_frame(make_frame(THUMB_L_BIT | PRIMARY_BIT, 0, 0, 0, 0, 0, 0, 0, 0, t + 10));
      queue_frame(make_frame(THUMB_L_BIT | PRIMARY_BIT, 0, 0, 0, 0, 0, 0, 0, 16384, t + 11));
      queue_frame(make_frame(PRIMARY_BIT, 0, 0, 0, 0, 0, 0, 0, 16384, t + 12));
      // hand beside head: radius and height edges, missing flags
      queue_frame(make_frame(HEAD_PAIR, 1943, -414, -300, 100, 200, -300, -16384, 0, t + 13));
      queue_frame(make_frame(HEAD_PAIR, 1944, -414, -300, 100, 200, -300, -16384, 0, t + 14));
      queue_frame(make_frame(HEAD_PAIR | PRIMARY_BIT, 1403, -414, 1003, 100, 200, -300,
                             0, 16384, t + 15));
      queue_frame(make_frame(HEAD_PAIR, 100, -415, -300, 100, 200, -300, 0, 16384, t + 16));
      queue_frame(make_frame(TRACKED_BIT, 100, 200, -300, 100, 200, -300, 0, 16384, t + 17));
      queue_frame(make_frame(HEAD_OK_BIT, 100, 200, -300, 100, 200, -300, 0, 16384, t + 18));
      // extreme positions and timestamps
      queue_frame(make_frame(5'h1f, 32767, 32767, 32767, -32768, -32768, -32768,
                             32767, -32768, 32'hffff_ffff));
      queue_frame(make_frame(5'h1f, -32768, -32768, -32768, 32767, 32767, 32767,
                             0, 0, 32'd0));
      wait_idle();

      // dwell across the timestamp wrap
      write_reg(REG_DWELL_MS, 16'd100);
      queue_frame(make_frame(5'd0, 0, 0, 0, 0, 0, 0, 0, 0, 32'hffff_ffb0));
      queue_frame(make_frame(THUMB_L_BIT, 0, 0, 0, 0, 0, 0, 0, 16384, 32'hffff_ffc0));
      queue_frame(make_frame(THUMB_L_BIT, 0, 0, 0, 0, 0, 0, 0, 16384, 32'hffff_fff2));
      queue_frame(make_frame(THUMB_L_BIT, 0, 0, 0, 0, 0, 0, 0, 16384, 32'h0000_0024));
      queue_frame(make_frame(THUMB_L_BIT, 0, 0, 0, 0, 0, 0, 0, 16384, 32'h0000_0025));

      // random phases under different register settings
      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         configure(phase);
         queue_sessions(70);
      end
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && shift_expected.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
